[rtl/bdms_pkg.sv]
// Package for the bounded deque unit: command and status codes, sizes.
// No dependencies.
package bdms_pkg;
  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W = 32;
  localparam int DATA_W = 40;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_MEAN       = 3'd4,
    MODE_SORT       = 3'd5,
    MODE_READ_FIRST = 3'd6,
    MODE_UNUSED     = 3'd7
  } mode_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_POP_FRONT, CMD_POP_BACK,
    CMD_SUM_START, CMD_SUM_STEP, CMD_DIV_START, CMD_DIV_STEP,
    CMD_SORT_START, CMD_SORT_READ, CMD_SORT_CMP, CMD_SORT_NEXT, CMD_READ_FIRST
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic sum_done;
    logic div_done;
    logic sort_done;
  } stat_t;
endpackage

[rtl/bdms_datapath.sv]
// Datapath: circular store, head and count, summation, serial divider, sort.
// Depends on bdms_pkg.
module bdms_datapath #(
  parameter int DEPTH = bdms_pkg::DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  bdms_pkg::cmd_t cmd,
  input  logic [bdms_pkg::VALUE_W-1:0] value,
  output bdms_pkg::stat_t stat,
  output logic signed [bdms_pkg::DATA_W-1:0] mean,
  output logic signed [bdms_pkg::VALUE_W-1:0] first
);
  import bdms_pkg::*;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = VALUE_W + CW + 8;
  localparam int QW = SW;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] pi, pj;
  logic [VALUE_W-1:0] rd;
  logic [VALUE_W-1:0] ra;
  logic [SW-1:0] sum;
  logic [QW-1:0] quo;
  logic [SW:0] rem;
  logic neg;
  logic [$clog2(QW+1)-1:0] bitc;
  logic phase;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, h} + {1'b0, p};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  logic [IW-1:0] head_m1;
  assign head_m1 = (head == '0) ? IW'(DEPTH - 1) : head - 1'b1;
  logic [IW-1:0] rd_addr;
  always_comb begin
    case (cmd)
      CMD_SORT_READ: rd_addr = slot(head, pj);
      CMD_SORT_START: rd_addr = head;
      default: rd_addr = (phase) ? slot(head, pj) : slot(head, pi);
    endcase
  end

  logic [SW:0] trial;
  assign trial = {rem[SW-1:0], quo[QW-1]} - {1'b0, {(SW-CW){1'b0}}, count};

  always_ff @(posedge clk) begin
    rd <= mem[rd_addr];
    first <= mem[head];
    if (rst) begin
      head <= '0;
      count <= '0;
    end else begin
      case (cmd)
        CMD_PUSH_FRONT: begin
          head <= head_m1;
          mem[head_m1] <= value;
          count <= count + 1'b1;
        end
        CMD_PUSH_BACK: begin
          mem[slot(head, count)] <= value;
          count <= count + 1'b1;
        end
        CMD_POP_FRONT: begin
          head <= (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
          count <= count - 1'b1;
        end
        CMD_POP_BACK: count <= count - 1'b1;
        CMD_SUM_START: begin
          sum <= '0;
          pi <= '0;
          phase <= 1'b0;
        end
        CMD_SUM_STEP: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            sum <= sum + SW'(signed'(rd));
            pi <= pi + 1'b1;
            phase <= 1'b0;
          end
        end
        CMD_DIV_START: begin
          neg <= sum[SW-1];
          quo <= (sum[SW-1] ? -sum : sum) << 8;
          rem <= '0;
          bitc <= '0;
        end
        CMD_DIV_STEP: begin
          if (!trial[SW]) begin
            rem <= trial;
            quo <= {quo[QW-2:0], 1'b1};
          end else begin
            rem <= {rem[SW-1:0], quo[QW-1]};
            quo <= {quo[QW-2:0], 1'b0};
          end
          bitc <= bitc + 1'b1;
        end
        CMD_SORT_START: begin
          pi <= '0;
          pj <= CW'(1);
          phase <= 1'b0;
        end
        CMD_SORT_READ: begin
          if (!phase) ra <= rd;
          phase <= 1'b1;
        end
        CMD_SORT_CMP: begin
          if (signed'(ra) > signed'(rd)) begin
            mem[slot(head, pi)] <= rd;
            mem[slot(head, pj)] <= ra;
            ra <= rd;
          end
          phase <= 1'b1;
        end
        CMD_SORT_NEXT: begin
          if (pj + 1'b1 >= count) begin
            pi <= pi + 1'b1;
            pj <= pi + 2'd2;
            phase <= 1'b0;
          end else begin
            pj <= pj + 1'b1;
            phase <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign mean = neg ? -DATA_W'(quo) : DATA_W'(quo);
  assign stat.full = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign stat.sum_done = (pi == count);
  assign stat.div_done = (bitc == ($clog2(QW+1))'(QW));
  assign stat.sort_done = (pi + 1'b1 >= count) || (count == '0);
endmodule

[rtl/bdms_ctrl.sv]
// Controller: sequences each command and drives the result register.
// Depends on bdms_pkg.
module bdms_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] mode,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic signed [bdms_pkg::DATA_W-1:0] data,
  output bdms_pkg::cmd_t cmd,
  input  bdms_pkg::stat_t stat,
  input  logic signed [bdms_pkg::DATA_W-1:0] mean,
  input  logic signed [bdms_pkg::VALUE_W-1:0] first
);
  import bdms_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_DIV0, S_DIV, S_MEANOUT, S_SORT0, S_SRD, S_SWAIT,
    S_SCMP, S_SNEXT, S_READ
  } state_t;
  state_t state;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  logic acc;
  assign acc = in_valid && !in_stall;

  always_comb begin
    cmd = CMD_NONE;
    case (state)
      S_IDLE: if (acc) begin
        case (mode_t'(mode))
          MODE_PUSH_FRONT: if (!stat.full) cmd = CMD_PUSH_FRONT;
          MODE_PUSH_BACK: if (!stat.full) cmd = CMD_PUSH_BACK;
          MODE_POP_FRONT: if (!stat.empty) cmd = CMD_POP_FRONT;
          MODE_POP_BACK: if (!stat.empty) cmd = CMD_POP_BACK;
          MODE_MEAN: cmd = CMD_SUM_START;
          MODE_SORT: cmd = CMD_SORT_START;
          default: cmd = CMD_NONE;
        endcase
      end
      S_SUM: cmd = stat.sum_done ? CMD_NONE : CMD_SUM_STEP;
      S_DIV0: cmd = CMD_DIV_START;
      S_DIV: cmd = stat.div_done ? CMD_NONE : CMD_DIV_STEP;
      S_SRD: cmd = CMD_SORT_READ;
      S_SCMP: cmd = CMD_SORT_CMP;
      S_SNEXT: cmd = CMD_SORT_NEXT;
      default: cmd = CMD_NONE;
    endcase
  end

  logic res_done;
  always_comb begin
    res_done = 1'b0;
    case (state)
      S_IDLE: if (acc) begin
        case (mode_t'(mode))
          MODE_MEAN, MODE_SORT: res_done = 1'b0;
          MODE_READ_FIRST: res_done = stat.empty;
          default: res_done = 1'b1;
        endcase
      end
      S_READ, S_MEANOUT: res_done = 1'b1;
      S_SORT0: res_done = stat.sort_done;
      default: res_done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_done || (out_valid && out_stall);
      case (state)
        S_IDLE: if (acc) begin
          data <= '0;
          case (mode_t'(mode))
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              status <= stat.full ? STATUS_FULL : STATUS_OK;
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              status <= stat.empty ? STATUS_EMPTY : STATUS_OK;
            end
            MODE_MEAN: begin
              status <= STATUS_OK;
              state <= S_SUM;
            end
            MODE_SORT: begin
              status <= STATUS_OK;
              state <= S_SORT0;
            end
            MODE_READ_FIRST: begin
              status <= stat.empty ? STATUS_EMPTY : STATUS_OK;
              if (!stat.empty) state <= S_READ;
            end
            default: status <= STATUS_OK;
          endcase
        end
        S_READ: begin
          data <= DATA_W'(first);
          state <= S_IDLE;
        end
        S_SUM: if (stat.sum_done) state <= stat.empty ? S_MEANOUT : S_DIV0;
        S_DIV0: state <= S_DIV;
        S_DIV: if (stat.div_done) state <= S_MEANOUT;
        S_MEANOUT: begin
          if (!stat.empty) data <= mean;
          state <= S_IDLE;
        end
        S_SORT0: state <= stat.sort_done ? S_IDLE : S_SWAIT;
        S_SWAIT: state <= S_SRD;
        S_SRD: state <= S_SCMP;
        S_SCMP: state <= S_SNEXT;
        S_SNEXT: state <= S_SORT0;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/bounded_deque_mean_sort_unit.sv]
// Bounded deque of signed 32-bit values with mean and ascending sort.
// Push, pop and mode seven: result in the cycle after transfer; read first: via S_READ.
// Mean: summing loop, then 45-step serial divider (at the default DEPTH).
// Sort: one compare-swap per pass through S_SORT0, S_SWAIT, S_SRD, S_SCMP, S_SNEXT.
// One item at a time. Synchronous reset empties the deque; store is not cleared.
module bounded_deque_mean_sort_unit #(
  parameter int DEPTH = bdms_pkg::DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] mode,
  input  logic signed [31:0] value,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic signed [39:0] data
);
  import bdms_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic signed [DATA_W-1:0] mean;
  logic signed [VALUE_W-1:0] first;

  bdms_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .mode, .out_valid, .out_stall,
    .status, .data, .cmd, .stat, .mean, .first
  );

  bdms_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .cmd, .value(value), .stat, .mean, .first
  );
endmodule
